/* hw/rtl/vks_pkg.sv */
// Package for the key velocity scanner: field widths, message codes and key entry type.
`default_nettype none
package vks_pkg;

   localparam int NumKeysDefault = 76;
   localparam int KEY_W          = 7;
   localparam int DATA_W         = 7;
   localparam int STATUS_W       = 8;

   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_CTRL    = 8'hB0;
   localparam logic [DATA_W-1:0]   CTRL_SUSTAIN   = 7'h40;
   localparam logic [DATA_W-1:0]   VEL_START      = 7'd127;
   localparam logic [DATA_W-1:0]   VEL_FLOOR      = 7'd1;
   localparam logic [DATA_W-1:0]   VEL_RELEASE    = 7'd0;
   localparam logic [DATA_W-1:0]   SUSTAIN_ON     = 7'd127;
   localparam logic [DATA_W-1:0]   SUSTAIN_OFF    = 7'd0;
   localparam logic [DATA_W-1:0]   NOTE_BASE_RST  = 7'd28;
   localparam logic                PEDAL_REST_RST = 1'b1;

   typedef enum logic [0:0] {
      CSR_PEDAL_REST = 1'b0,
      CSR_NOTE_BASE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              gate;
      logic [DATA_W-1:0] velocity;
   } key_entry_type;

   localparam int ENTRY_W = $bits(key_entry_type);

   localparam key_entry_type ENTRY_RST = '{gate: 1'b0, velocity: VEL_START};

endpackage
`default_nettype wire

/* hw/rtl/vks_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module vks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 76,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/velocity_key_scanner.sv */
// Top level of the two-contact key velocity scanner with sustain pedal.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall| mode, key, contact_first/second, pedal_level
//  rsp_    | out       | rsp_valid/rsp_stall| status_byte, data_first, data_second
//  csr_    | in        | csr_valid/csr_ready| index, data
//
// One item per cycle unless the output stalls. Each item reads its key entry from the key
// RAM on acceptance, is resolved in the cycle after and written back; a message, if any,
// goes to the output register. A write-back register forwards to the following read of
// the same key. Reset is synchronous; per-key valid flags make unwritten entries read as
// keys off, velocity 127. A stalled output holds the resolve stage and thus the input.
`default_nettype none
module velocity_key_scanner
   import vks_pkg::*;
#(
   parameter int NUM_KEYS = NumKeysDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_mode,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic                req_contact_first,
   input  wire logic                req_contact_second,
   input  wire logic                req_pedal_level,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status_byte,
   output logic [DATA_W-1:0]        rsp_data_first,
   output logic [DATA_W-1:0]        rsp_data_second,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_index,
   input  wire logic [DATA_W-1:0]   csr_data
);

   localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(NUM_KEYS);

   // configuration
   logic              pedal_rest_ff;
   logic [DATA_W-1:0] note_base_ff;
   logic              pedal_prev_ff, pedal_prev_in;

   // resolve stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_mode_ff;
   logic              s1_in_range_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic              s1_c1_ff, s1_c2_ff, s1_pedal_ff;

   // write-back forwarding
   logic              fwd_valid_ff;
   logic [AW-1:0]     fwd_addr_ff;
   key_entry_type     fwd_data_ff;

   logic [NUM_KEYS-1:0] entry_valid_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_d1_ff, rsp_d1_in;
   logic [DATA_W-1:0]   rsp_d2_ff, rsp_d2_in;

   logic              out_free, s1_done, req_take, csr_take;
   logic              req_in_range;
   logic [AW-1:0]     s1_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   key_entry_type     cur, nxt;
   logic              wr_en, emit;
   logic [DATA_W-1:0] note;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_done   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign req_in_range = req_key < KEY_LIMIT;
   assign s1_addr      = s1_key_ff[AW-1:0];
   assign note         = DATA_W'(s1_key_ff + note_base_ff);

   vks_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS),
      .AW    (AW)
   ) u_key_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (s1_addr),
      .wr_data    (nxt),
      .rd_en      (req_take),
      .rd_addr    (req_key[AW-1:0]),
      .rd_data_ff (ram_rd_data)
   );

   always_comb begin
      priority if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         cur = fwd_data_ff;
      end else if (entry_valid_ff[s1_addr]) begin
         cur = key_entry_type'(ram_rd_data);
      end else begin
         cur = ENTRY_RST;
      end
   end

   always_comb begin
      nxt           = cur;
      emit          = 1'b0;
      rsp_status_in = STATUS_NOTE_ON;
      rsp_d1_in     = note;
      rsp_d2_in     = cur.velocity;
      pedal_prev_in = pedal_prev_ff;
      if (s1_mode_ff) begin
         pedal_prev_in = s1_pedal_ff;
         rsp_status_in = STATUS_CTRL;
         rsp_d1_in     = CTRL_SUSTAIN;
         rsp_d2_in     = (s1_pedal_ff != pedal_rest_ff) ? SUSTAIN_ON : SUSTAIN_OFF;
         emit          = s1_pedal_ff != pedal_prev_ff;
      end else if (s1_in_range_ff) begin
         priority if (!cur.gate && s1_c1_ff && s1_c2_ff) begin
            nxt.gate = 1'b1;
            emit     = 1'b1;
         end else if (!cur.gate && (s1_c1_ff != s1_c2_ff)) begin
            if (cur.velocity > VEL_FLOOR) begin
               nxt.velocity = cur.velocity - 7'd1;
            end
         end else if (cur.gate && !s1_c1_ff && !s1_c2_ff) begin
            nxt       = ENTRY_RST;
            emit      = 1'b1;
            rsp_d2_in = VEL_RELEASE;
         end else begin
            nxt = cur;
         end
      end
      wr_en = s1_done && !s1_mode_ff && s1_in_range_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_done) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         pedal_rest_ff  <= PEDAL_REST_RST;
         pedal_prev_ff  <= PEDAL_REST_RST;
         note_base_ff   <= NOTE_BASE_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            fwd_valid_ff            <= 1'b1;
            entry_valid_ff[s1_addr] <= 1'b1;
         end
         if (csr_take) begin
            unique case (csr_index_type'(csr_index))
               CSR_PEDAL_REST: begin
                  pedal_rest_ff <= csr_data[0];
                  pedal_prev_ff <= csr_data[0];
               end
               CSR_NOTE_BASE: begin
                  note_base_ff <= csr_data;
               end
               default: begin
                  note_base_ff <= note_base_ff;
               end
            endcase
         end else if (s1_done) begin
            pedal_prev_ff <= pedal_prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff     <= req_mode;
         s1_key_ff      <= req_key;
         s1_in_range_ff <= req_in_range;
         s1_c1_ff       <= req_contact_first;
         s1_c2_ff       <= req_contact_second;
         s1_pedal_ff    <= req_pedal_level;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= nxt;
      end
      if (s1_done && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_d1_ff     <= rsp_d1_in;
         rsp_d2_ff     <= rsp_d2_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = rsp_status_ff;
   assign rsp_data_first  = rsp_d1_ff;
   assign rsp_data_second = rsp_d2_ff;

endmodule
`default_nettype wire

/* verif/vks_checker.sv */
// Checker for the key velocity scanner: follows all three channels, predicts messages, compares.
module vks_checker
   import vks_pkg::*;
#(
   parameter int NUM_KEYS = NumKeysDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_mode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic                req_contact_first,
   input  logic                req_contact_second,
   input  logic                req_pedal_level,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status_byte,
   input  logic [DATA_W-1:0]   rsp_data_first,
   input  logic [DATA_W-1:0]   rsp_data_second,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic                csr_index,
   input  logic [DATA_W-1:0]   csr_data,
   output int                  error_count,
   output int                  backlog
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   note;
      logic [DATA_W-1:0]   value;
   } midi_msg_type;

   midi_msg_type      midi_q[$];
   logic              key_down[NUM_KEYS];
   logic [DATA_W-1:0] key_vel[NUM_KEYS];
   logic              pedal_last;
   logic              rest_level;
   logic [DATA_W-1:0] base_note;
   int                errors = 0;

   task automatic track_sample();
      midi_msg_type msg;
      int           k;
      k = int'(req_key);
      if (req_mode) begin
         if (req_pedal_level != pedal_last) begin
            msg.status = STATUS_CTRL;
            msg.note   = CTRL_SUSTAIN;
            msg.value  = (req_pedal_level != rest_level) ? SUSTAIN_ON : SUSTAIN_OFF;
            midi_q.push_back(msg);
         end
         pedal_last = req_pedal_level;
      end else if (k < NUM_KEYS) begin
         msg.status = STATUS_NOTE_ON;
         msg.note   = DATA_W'(req_key + base_note);   // wraps at 128
         if (!key_down[k] && req_contact_first && req_contact_second) begin
            key_down[k] = 1'b1;
            msg.value   = key_vel[k];
            midi_q.push_back(msg);
         end else if (!key_down[k] && (req_contact_first != req_contact_second)) begin
            if (key_vel[k] > VEL_FLOOR)
               key_vel[k] = key_vel[k] - 7'd1;
         end else if (key_down[k] && !req_contact_first && !req_contact_second) begin
            key_down[k] = 1'b0;
            key_vel[k]  = VEL_START;
            msg.value   = VEL_RELEASE;
            midi_q.push_back(msg);
         end
      end
   endtask

   always @(posedge clock) begin
      midi_msg_type want;
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_down[i] = 1'b0;
            key_vel[i]  = VEL_START;
         end
         pedal_last = PEDAL_REST_RST;
         rest_level = PEDAL_REST_RST;
         base_note  = NOTE_BASE_RST;
         midi_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PEDAL_REST) begin
               rest_level = csr_data[0];
               pedal_last = csr_data[0];
            end else begin
               base_note = csr_data;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (midi_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected message %h %h %h", $time,
                        rsp_status_byte, rsp_data_first, rsp_data_second);
            end else begin
               want = midi_q.pop_front();
               if (rsp_status_byte != want.status) begin
                  errors++;
                  $display("%0t: status expected %h got %h", $time,
                           want.status, rsp_status_byte);
               end
               if (rsp_data_first != want.note) begin
                  errors++;
                  $display("%0t: data_first expected %0d got %0d", $time,
                           want.note, rsp_data_first);
               end
               if (rsp_data_second != want.value) begin
                  errors++;
                  $display("%0t: data_second expected %0d got %0d", $time,
                           want.value, rsp_data_second);
               end
            end
         end
         if (req_valid && !req_stall)
            track_sample();
      end
      error_count <= errors;
      backlog     <= midi_q.size();
   end

endmodule

/* verif/tb_velocity_key_scanner.sv */
// Testbench top for the key velocity scanner: drives samples and register writes, gives the verdict.
module tb_velocity_key_scanner;
   import vks_pkg::*;

   localparam int NUM_KEYS    = NumKeysDefault;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 6;

   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_mode           = 1'b0;
   logic [KEY_W-1:0]    req_key            = '0;
   logic                req_contact_first  = 1'b0;
   logic                req_contact_second = 1'b0;
   logic                req_pedal_level    = 1'b0;
   logic                rsp_stall          = 1'b0;
   logic                csr_valid          = 1'b0;
   logic                csr_index          = CSR_PEDAL_REST;
   logic [DATA_W-1:0]   csr_data           = '0;
   wire                 req_stall;
   wire                 rsp_valid;
   wire                 csr_ready;
   wire [STATUS_W-1:0]  rsp_status_byte;
   wire [DATA_W-1:0]    rsp_data_first;
   wire [DATA_W-1:0]    rsp_data_second;
   int                  error_count;
   int                  backlog;

   int                  items_sent   = 0;
   int                  burst_left   = 0;
   int                  quiet_cycles = 0;
   int                  stall_left   = 0;
   stall_mode_type      stall_kind   = STALL_NONE;

   velocity_key_scanner #(.NUM_KEYS(NUM_KEYS)) dut (.*);

   vks_checker #(.NUM_KEYS(NUM_KEYS)) u_check (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver stall pattern, picks a new stall mode and a random run length when a run ends
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("velocity_key_scanner test failed");
      $finish;
   end

   task automatic send_item(input logic m, input logic [KEY_W-1:0] k, input logic c1,
                            input logic c2, input logic pl);
      int gap;
      req_valid          <= 1'b1;
      req_mode           <= m;
      req_key            <= k;
      req_contact_first  <= c1;
      req_contact_second <= c2;
      req_pedal_level    <= pl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_key(input logic [KEY_W-1:0] k, input logic c1, input logic c2);
      send_item(1'b0, k, c1, c2, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_pedal(input logic pl);
      send_item(1'b1, KEY_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), pl);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // half-travel on one contact, strike, some bounce while held, then optional lift
   task automatic play_key(input int k, input int travel, input bit lift);
      logic             upper;
      int               held;
      logic [KEY_W-1:0] key_sel;
      key_sel = KEY_W'(k);
      repeat (travel) begin
         upper = 1'($urandom_range(0, 1));
         send_key(key_sel, upper, !upper);
      end
      send_key(key_sel, 1'b1, 1'b1);
      held = $urandom_range(0, 3);
      repeat (held) begin
         upper = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 0)
            send_key(key_sel, 1'b1, 1'b1);
         else
            send_key(key_sel, upper, !upper);
      end
      if (lift) begin
         repeat ($urandom_range(0, 2)) begin
            upper = 1'($urandom_range(0, 1));
            send_key(key_sel, upper, !upper);
         end
         send_key(key_sel, 1'b0, 1'b0);
      end
   endtask

   task automatic random_phase(input int count);
      int stop;
      int pick;
      int travel;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            travel = ($urandom_range(0, 39) == 0) ? $urandom_range(126, 135)
                                                  : $urandom_range(0, 12);
            play_key($urandom_range(0, NUM_KEYS - 1), travel, $urandom_range(0, 7) != 0);
         end else if (pick < 75) begin
            send_pedal(1'($urandom_range(0, 1)));
         end else if (pick < 78) begin
            settle();
         end else begin
            send_item(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rest level high, base 28
      send_key(0, 1'b1, 1'b0);
      send_key(0, 1'b0, 1'b1);
      send_key(0, 1'b1, 1'b1);
      send_key(0, 1'b1, 1'b0);
      send_key(0, 1'b1, 1'b1);
      send_key(0, 1'b0, 1'b0);
      send_key(0, 1'b0, 1'b0);
      send_key(75, 1'b1, 1'b1);
      send_key(75, 1'b0, 1'b0);
      send_key(76, 1'b1, 1'b1);
      send_key(127, 1'b1, 1'b1);
      send_key(127, 1'b0, 1'b0);
      send_pedal(1'b1);
      send_pedal(1'b0);
      send_pedal(1'b0);
      send_pedal(1'b1);
      send_item(1'b1, 127, 1'b1, 1'b1, 1'b0);
      send_item(1'b1, 0, 1'b0, 1'b0, 1'b1);
      send_item(1'b0, 42, 1'b1, 1'b1, 1'b1);
      send_item(1'b0, 42, 1'b0, 1'b0, 1'b0);
      settle();

      // one key held on a single contact until the velocity floor
      play_key($urandom_range(0, NUM_KEYS - 1), 130, 1'b1);
      random_phase(110);
      settle();

      write_reg(CSR_PEDAL_REST, 7'h7E);
      write_reg(CSR_NOTE_BASE, 7'd0);
      send_pedal(1'b0);
      send_pedal(1'b1);
      send_pedal(1'b0);
      play_key(75, 2, 1'b1);
      random_phase(110);
      settle();

      write_reg(CSR_NOTE_BASE, 7'd127);
      write_reg(CSR_PEDAL_REST, 7'h01);
      play_key(1, 1, 1'b1);
      play_key(75, 0, 1'b1);
      random_phase(110);
      settle();

      write_reg(CSR_NOTE_BASE, DATA_W'($urandom_range(1, 126)));
      write_reg(CSR_PEDAL_REST, DATA_W'($urandom_range(0, 127)));
      random_phase(110);
      settle();

      if (error_count == 0 && backlog == 0)
         $display("velocity_key_scanner test passed");
      else
         $display("velocity_key_scanner test failed");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/vks_pkg.sv
hw/rtl/vks_ram.sv
hw/rtl/velocity_key_scanner.sv
verif/vks_checker.sv
verif/tb_velocity_key_scanner.sv
